// File: src/msd_pkg.sv
// Motor drive supervisor package: word types, codes and constants.
// No dependencies; used by the interfaces, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package msd_pkg;

    localparam int DUTY_BITS = 12;
    localparam int CALC_W    = 18;
    localparam int OUT_DUTY_W = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [DUTY_BITS-1:0] DUTY_TOP = '1;

    localparam logic [1:0] FUNC_DUTY = 2'd0;
    localparam logic [1:0] FUNC_MODE = 2'd1;
    localparam logic [1:0] FUNC_SCAN = 2'd2;

    localparam logic [7:0] CMD_STOP  = 8'd0;
    localparam logic [7:0] CMD_START = 8'd1;
    localparam logic [7:0] CMD_CLEAR = 8'd9;

    localparam logic [2:0] HALL_LOW  = 3'd0;
    localparam logic [2:0] HALL_HIGH = 3'h7;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_DISABLED  = 2'd1;
    localparam logic [1:0] STAT_TRIPPED   = 2'd2;
    localparam logic [1:0] STAT_UNDERVOLT = 2'd3;

    localparam logic [1:0] MODE_CODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_CODE_START = 2'd1;
    localparam logic [1:0] MODE_CODE_RUN   = 2'd2;
    localparam logic [1:0] MODE_CODE_FAULT = 2'd3;

    localparam int FLAG_HALL        = 0;
    localparam int FLAG_OVERCURRENT = 1;
    localparam int FLAG_UNDERVOLT   = 2;
    localparam int FLAG_STALL       = 3;

    localparam logic [2:0] CFG_DRIVE_ENABLE = 3'd0;
    localparam logic [2:0] CFG_DUTY_FLOOR   = 3'd1;
    localparam logic [2:0] CFG_DUTY_CEILING = 3'd2;
    localparam logic [2:0] CFG_SLEW_STEP    = 3'd3;
    localparam logic [2:0] CFG_STALL_RPM    = 3'd4;
    localparam logic [2:0] CFG_UNDERVOLT_MV = 3'd5;
    localparam logic [2:0] CFG_OC_LIMIT     = 3'd6;

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'b0001,
        MODE_START = 4'b0010,
        MODE_RUN   = 4'b0100,
        MODE_FAULT = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [15:0] duty_request;
        logic [7:0]         command_code;
        logic [2:0]         hall_code;
        logic signed [15:0] current_sample;
        logic [15:0]        bus_millivolts;
        logic [15:0]        speed_rpm;
        logic               estop;
    } t_in_word;

    typedef struct packed {
        logic [1:0]            status;
        logic [OUT_DUTY_W-1:0] applied_duty;
        logic                  pwm_write;
        logic [1:0]            mode_now;
        logic [3:0]            fault_mask;
    } t_out_word;

    function automatic logic [DUTY_BITS-1:0] sat_duty(input logic [11:0] v);
        logic [CALC_W-1:0] wide_v;
        logic [CALC_W-1:0] wide_top;
        wide_v   = {{(CALC_W-12){1'b0}}, v};
        wide_top = {{(CALC_W-DUTY_BITS){1'b0}}, DUTY_TOP};
        if (wide_v > wide_top) begin
            return DUTY_TOP;
        end
        return wide_v[DUTY_BITS-1:0];
    endfunction

    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] c;
        unique case (m)
            MODE_IDLE:  c = MODE_CODE_IDLE;
            MODE_START: c = MODE_CODE_START;
            MODE_RUN:   c = MODE_CODE_RUN;
            MODE_FAULT: c = MODE_CODE_FAULT;
            default:    c = MODE_CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: src/msd_in_if.sv
// Input channel of the motor drive supervisor: valid, ready and one input word.
// Depends on msd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface msd_in_if
    import msd_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/msd_out_if.sv
// Result channel of the motor drive supervisor: valid, ready and one result word.
// Depends on msd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface msd_out_if
    import msd_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/motor_drive_supervisor.sv
// Motor drive supervisor top level: input register, update logic, result register.
// Depends on msd_pkg, msd_in_if and msd_out_if.
//
// Usage:
//   i_in  : input words (duty request, mode command, fault scan), valid/ready.
//   o_out : one result word per input word, valid/ready, in input order.
//   i_cfg_*: register writes, taken at any edge with i_cfg_we high; write
//            only while no word is in flight.
// Path: an accepted word is held in the input register, then its result in the result register.
// Throughput: one word per cycle while o_out is not held; the state update is
//   a single pass of compare and select logic between the input and result registers.
// Reset (synchronous, active low): both stages empty, mode idle, duty and
//   fault flags zero, registers to their defaults.
// Stall: while o_out is held, the result register keeps its word and one
//   more word is taken into the input register; i_in.ready then drops
//   until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module motor_drive_supervisor
    import msd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    msd_in_if.sink                     i_in,
    msd_out_if.source                  o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic        r_drive_enable;
    logic [11:0] r_duty_floor;
    logic [11:0] r_duty_ceiling;
    logic [11:0] r_slew_step;
    logic [15:0] r_stall_rpm;
    logic [15:0] r_undervolt_mv;
    logic [14:0] r_oc_limit;

    t_mode                r_mode, n_mode;
    logic [DUTY_BITS-1:0] r_duty, n_duty;
    logic [3:0]           r_flags, n_flags;

    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out, n_out;

    logic advance;

    logic signed [CALC_W-1:0] s_target, s_lo, s_hi, s_cur, s_slew, s_clamp, s_delta, s_step;
    logic signed [16:0]       s_amps, s_lim;
    logic                     bus_low, rpm_below, rpm_above, duty_above_slew;
    logic [1:0]               n_status;
    logic                     n_pwm;
    logic [3:0]               scan_mask;

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_enable <= 1'b0;
            r_duty_floor   <= 12'd0;
            r_duty_ceiling <= 12'd4095;
            r_slew_step    <= 12'd64;
            r_stall_rpm    <= 16'd100;
            r_undervolt_mv <= 16'd9000;
            r_oc_limit     <= 15'd5000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DRIVE_ENABLE: r_drive_enable <= i_cfg_data[0];
                CFG_DUTY_FLOOR:   r_duty_floor   <= i_cfg_data[11:0];
                CFG_DUTY_CEILING: r_duty_ceiling <= i_cfg_data[11:0];
                CFG_SLEW_STEP:    r_slew_step    <= i_cfg_data[11:0];
                CFG_STALL_RPM:    r_stall_rpm    <= i_cfg_data;
                CFG_UNDERVOLT_MV: r_undervolt_mv <= i_cfg_data;
                CFG_OC_LIMIT:     r_oc_limit     <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        s_target = {{(CALC_W-16){r_in.duty_request[15]}}, r_in.duty_request};
        s_lo     = {{(CALC_W-DUTY_BITS){1'b0}}, sat_duty(r_duty_floor)};
        s_hi     = {{(CALC_W-DUTY_BITS){1'b0}}, sat_duty(r_duty_ceiling)};
        s_cur    = {{(CALC_W-DUTY_BITS){1'b0}}, r_duty};
        s_slew   = {{(CALC_W-12){1'b0}}, r_slew_step};

        if (s_target < s_lo) begin
            s_clamp = s_lo;
        end else if (s_target > s_hi) begin
            s_clamp = s_hi;
        end else begin
            s_clamp = s_target;
        end
        s_delta = s_clamp - s_cur;
        if (s_delta > s_slew) begin
            s_step = s_cur + s_slew;
        end else if (s_delta < -s_slew) begin
            s_step = s_cur - s_slew;
        end else begin
            s_step = s_clamp;
        end

        bus_low   = r_in.bus_millivolts < r_undervolt_mv;
        rpm_below = r_in.speed_rpm < r_stall_rpm;
        rpm_above = r_in.speed_rpm > r_stall_rpm;
        duty_above_slew = s_cur > s_slew;

        s_amps = {r_in.current_sample[15], r_in.current_sample};
        s_lim  = {2'b00, r_oc_limit};
        scan_mask = 4'd0;
        scan_mask[FLAG_HALL]        = (r_in.hall_code == HALL_LOW)
                                   || (r_in.hall_code == HALL_HIGH);
        scan_mask[FLAG_OVERCURRENT] = (s_amps > s_lim) || (s_amps < -s_lim);
        scan_mask[FLAG_UNDERVOLT]   = bus_low;
        scan_mask[FLAG_STALL]       = (r_mode == MODE_RUN) && rpm_below
                                   && !scan_mask[FLAG_OVERCURRENT];
    end

    always_comb begin
        n_mode   = r_mode;
        n_duty   = r_duty;
        n_flags  = r_flags;
        n_status = STAT_OK;
        n_pwm    = 1'b0;
        case (r_in.func)
            FUNC_DUTY: begin
                if (!r_drive_enable) begin
                    n_status = STAT_DISABLED;
                end else if (r_in.estop || r_flags[FLAG_OVERCURRENT]) begin
                    n_duty   = '0;
                    n_pwm    = 1'b1;
                    n_status = STAT_TRIPPED;
                end else if (bus_low && (s_step > s_cur)) begin
                    n_flags[FLAG_UNDERVOLT] = 1'b1;
                    n_status = STAT_UNDERVOLT;
                end else begin
                    n_duty = s_step[DUTY_BITS-1:0];
                    n_pwm  = 1'b1;
                end
            end
            FUNC_MODE: begin
                unique case (r_mode)
                    MODE_IDLE: begin
                        if (r_in.command_code == CMD_START && r_drive_enable) begin
                            n_mode = MODE_START;
                        end
                    end
                    MODE_START: begin
                        if (r_flags[FLAG_HALL] || r_flags[FLAG_OVERCURRENT]) begin
                            n_mode = MODE_FAULT;
                        end else if (rpm_above) begin
                            n_mode = MODE_RUN;
                        end
                    end
                    MODE_RUN: begin
                        if (r_in.command_code == CMD_STOP) begin
                            n_mode = MODE_IDLE;
                        end else if (rpm_below && duty_above_slew) begin
                            n_flags[FLAG_STALL] = 1'b1;
                            n_mode = MODE_FAULT;
                        end
                    end
                    MODE_FAULT: begin
                        if (r_in.command_code == CMD_CLEAR && r_flags == 4'd0) begin
                            n_mode = MODE_IDLE;
                        end
                    end
                    default: n_mode = MODE_IDLE;
                endcase
            end
            FUNC_SCAN: begin
                n_flags = scan_mask;
            end
            default: ;
        endcase

        n_out.status       = n_status;
        n_out.applied_duty = OUT_DUTY_W'(n_duty);
        n_out.pwm_write    = n_pwm;
        n_out.mode_now     = mode_code(n_mode);
        n_out.fault_mask   = n_flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_IDLE;
            r_duty      <= '0;
            r_flags     <= 4'd0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_duty      <= n_duty;
                r_flags     <= n_flags;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// File: src/msd_checker.sv
// Port-level checks for the motor drive supervisor, bound to the top level.
// Depends on msd_pkg and motor_drive_supervisor.
`timescale 1ns / 1ps
`default_nettype none

module msd_checker
    import msd_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_word i_out_data
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result word changed");

    a_trip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status == STAT_TRIPPED
        |-> i_out_data.applied_duty == '0 && i_out_data.pwm_write)
        else $error("trip without zero duty write");

    a_undervolt_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status == STAT_UNDERVOLT
        |-> i_out_data.fault_mask[FLAG_UNDERVOLT] && !i_out_data.pwm_write)
        else $error("undervolt refusal wrote duty or missed flag");

    a_disabled_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status == STAT_DISABLED |-> !i_out_data.pwm_write)
        else $error("disabled drive wrote duty");

endmodule

bind motor_drive_supervisor msd_checker u_msd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

`default_nettype wire

// File: verif/motor_drive_supervisor_tb.sv
// Testbench for motor_drive_supervisor: directed and random words, checked field by field
// against an in-bench model of the drive supervisor across several register settings.
// Depends on msd_pkg, msd_in_if, msd_out_if and the motor_drive_supervisor top level.
`timescale 1ns / 1ps

module motor_drive_supervisor_tb;
    import msd_pkg::*;

    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam int QUIET_LIMIT = 5000;
    localparam int LONG_HOLD   = 300;
    localparam int HOLD_AT     = 400;
    localparam int PHASE_WORDS = 152;
    localparam int PHASES      = 10;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    msd_in_if  in_ch();
    msd_out_if out_ch();

    motor_drive_supervisor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // register copies
    logic        drive_on = 1'b0;
    logic [11:0] duty_lo = 12'd0;
    logic [11:0] duty_hi = 12'd4095;
    logic [11:0] slew_lim = 12'd64;
    logic [15:0] stall_lim = 16'd100;
    logic [15:0] uv_mv = 16'd9000;
    logic [14:0] oc_lim = 15'd5000;

    // supervisor state
    logic [1:0]  drive_mode = MODE_CODE_IDLE;
    logic [11:0] held_duty = '0;
    logic [3:0]  held_flags = '0;

    t_in_word  pending_words[$];
    t_out_word expected_results[$];

    int words_queued = 0;
    int results_checked = 0;
    int failures = 0;
    int settings_applied = 0;
    int run_results = 0;
    int trip_results = 0;
    int uv_refusals = 0;
    bit no_idle = 1'b0;
    bit long_hold_done = 1'b0;
    int send_gap = 0;
    int hold_left = 0;

    function automatic t_out_word supervise_word(input t_in_word w);
        t_out_word  r;
        int         target, lo, hi, cur, step, t, amps, lim;
        logic [3:0] mask;
        r = '0;
        r.status = STAT_OK;
        r.pwm_write = 1'b0;
        case (w.func)
            FUNC_DUTY: begin
                if (!drive_on) begin
                    r.status = STAT_DISABLED;
                end else if (w.estop || held_flags[FLAG_OVERCURRENT]) begin
                    held_duty = '0;
                    r.pwm_write = 1'b1;
                    r.status = STAT_TRIPPED;
                end else begin
                    target = $signed(w.duty_request);
                    lo = duty_lo;
                    hi = duty_hi;
                    cur = held_duty;
                    step = slew_lim;
                    t = target < lo ? lo : (target > hi ? hi : target);
                    if (t - cur > step) begin
                        t = cur + step;
                    end else if (t - cur < -step) begin
                        t = cur - step;
                    end
                    if (w.bus_millivolts < uv_mv && t > cur) begin
                        held_flags[FLAG_UNDERVOLT] = 1'b1;
                        r.status = STAT_UNDERVOLT;
                    end else begin
                        held_duty = t[11:0];
                        r.pwm_write = 1'b1;
                    end
                end
            end
            FUNC_MODE: begin
                case (drive_mode)
                    MODE_CODE_IDLE: begin
                        if (w.command_code == CMD_START && drive_on) drive_mode = MODE_CODE_START;
                    end
                    MODE_CODE_START: begin
                        if (held_flags[FLAG_HALL] || held_flags[FLAG_OVERCURRENT]) begin
                            drive_mode = MODE_CODE_FAULT;
                        end else if (w.speed_rpm > stall_lim) begin
                            drive_mode = MODE_CODE_RUN;
                        end
                    end
                    MODE_CODE_RUN: begin
                        if (w.command_code == CMD_STOP) begin
                            drive_mode = MODE_CODE_IDLE;
                        end else if (w.speed_rpm < stall_lim && held_duty > slew_lim) begin
                            held_flags[FLAG_STALL] = 1'b1;
                            drive_mode = MODE_CODE_FAULT;
                        end
                    end
                    default: begin
                        if (w.command_code == CMD_CLEAR && held_flags == '0) begin
                            drive_mode = MODE_CODE_IDLE;
                        end
                    end
                endcase
            end
            FUNC_SCAN: begin
                mask = '0;
                amps = $signed(w.current_sample);
                lim = oc_lim;
                if (w.hall_code == HALL_LOW || w.hall_code == HALL_HIGH) mask[FLAG_HALL] = 1'b1;
                if (amps > lim || amps < -lim) mask[FLAG_OVERCURRENT] = 1'b1;
                if (w.bus_millivolts < uv_mv) mask[FLAG_UNDERVOLT] = 1'b1;
                if (drive_mode == MODE_CODE_RUN && w.speed_rpm < stall_lim
                        && !mask[FLAG_OVERCURRENT]) begin
                    mask[FLAG_STALL] = 1'b1;
                end
                held_flags = mask;
            end
            default: begin
            end
        endcase
        r.applied_duty = held_duty;
        r.mode_now = drive_mode;
        r.fault_mask = held_flags;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_word rand_word();
        t_in_word w;
        int       r, v, lim;
        r = $urandom_range(0, 99);
        if (r < 40) w.func = FUNC_DUTY;
        else if (r < 65) w.func = FUNC_MODE;
        else if (r < 95) w.func = FUNC_SCAN;
        else w.func = FUNC_SPARE;

        r = $urandom_range(0, 99);
        if (r < 20) v = $urandom;
        else if (r < 30) v = -$urandom_range(1, 3000);
        else v = $urandom_range(0, 4095);
        w.duty_request = v[15:0];

        r = $urandom_range(0, 99);
        if (r < 35) w.command_code = CMD_START;
        else if (r < 55) w.command_code = CMD_STOP;
        else if (r < 75) w.command_code = CMD_CLEAR;
        else w.command_code = 8'($urandom_range(0, 255));

        r = $urandom_range(0, 99);
        if (r < 85) w.hall_code = 3'($urandom_range(1, 6));
        else w.hall_code = r[0] ? HALL_HIGH : HALL_LOW;

        lim = oc_lim;
        r = $urandom_range(0, 99);
        if (r < 75) v = $urandom_range(0, lim);
        else if (r < 90) v = lim + $urandom_range(0, 1);
        else v = $urandom;
        if ($urandom_range(0, 1)) v = -v;
        w.current_sample = v[15:0];

        r = $urandom_range(0, 99);
        if (r < 80) v = $urandom_range(int'(uv_mv), 65535);
        else if (r < 90) v = int'(uv_mv) - 1 + $urandom_range(0, 1);
        else v = $urandom;
        w.bus_millivolts = v[15:0];

        r = $urandom_range(0, 99);
        if (r < 55) v = $urandom_range(int'(stall_lim), 65535);
        else if (r < 80) v = $urandom_range(0, int'(stall_lim));
        else v = $urandom;
        w.speed_rpm = v[15:0];

        w.estop = ($urandom_range(0, 99) < 6);
        return w;
    endfunction

    task automatic push_word(input t_in_word w);
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic push_fields(input logic [1:0] f, input int target, input int cmd,
                               input int hall, input int amps, input int bus, input int rpm,
                               input logic stop);
        t_in_word w;
        w.func = f;
        w.duty_request = target[15:0];
        w.command_code = cmd[7:0];
        w.hall_code = hall[2:0];
        w.current_sample = amps[15:0];
        w.bus_millivolts = bus[15:0];
        w.speed_rpm = rpm[15:0];
        w.estop = stop;
        push_word(w);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        case (idx)
            CFG_DRIVE_ENABLE: drive_on = value[0];
            CFG_DUTY_FLOOR:   duty_lo = value[11:0];
            CFG_DUTY_CEILING: duty_hi = value[11:0];
            CFG_SLEW_STEP:    slew_lim = value[11:0];
            CFG_STALL_RPM:    stall_lim = value[15:0];
            CFG_UNDERVOLT_MV: uv_mv = value[15:0];
            CFG_OC_LIMIT:     oc_lim = value[14:0];
            default: begin
            end
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input int enable, input int floor_v, input int ceil_v,
                                 input int slew, input int stall, input int uv, input int oc);
        write_reg(CFG_DRIVE_ENABLE, enable);
        write_reg(CFG_DUTY_FLOOR, floor_v);
        write_reg(CFG_DUTY_CEILING, ceil_v);
        write_reg(CFG_SLEW_STEP, slew);
        write_reg(CFG_STALL_RPM, stall);
        write_reg(CFG_UNDERVOLT_MV, uv);
        write_reg(CFG_OC_LIMIT, oc);
        @(posedge i_clk);
        settings_applied++;
    endtask

    task automatic wait_drained();
        while (results_checked != words_queued) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic check_result(input t_out_word got);
        t_out_word want;
        if (expected_results.size() == 0) begin
            $error("result word with nothing expected: %h", got);
            failures++;
        end else begin
            want = expected_results.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                failures++;
            end
            if (got.applied_duty !== want.applied_duty) begin
                $error("applied_duty: expected %0d, actual %0d",
                       want.applied_duty, got.applied_duty);
                failures++;
            end
            if (got.pwm_write !== want.pwm_write) begin
                $error("pwm_write: expected %0d, actual %0d", want.pwm_write, got.pwm_write);
                failures++;
            end
            if (got.mode_now !== want.mode_now) begin
                $error("mode_now: expected %0d, actual %0d", want.mode_now, got.mode_now);
                failures++;
            end
            if (got.fault_mask !== want.fault_mask) begin
                $error("fault_mask: expected %h, actual %h", want.fault_mask, got.fault_mask);
                failures++;
            end
            if (want.mode_now == MODE_CODE_RUN) run_results++;
            if (want.status == STAT_TRIPPED) trip_results++;
            if (want.status == STAT_UNDERVOLT) uv_refusals++;
        end
        results_checked++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) expected_results.push_back(supervise_word(in_ch.data));
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    in_ch.data <= pending_words.pop_front();
                    in_ch.valid <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) check_result(out_ch.data);
            if (results_checked == HOLD_AT && !long_hold_done) begin
                hold_left = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                hold_left = pick_gap();
                out_ch.ready <= (hold_left == 0);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
            else quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int p;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // drive disabled at reset defaults
        push_fields(FUNC_DUTY, 1000, 0, 3, 0, 12000, 0, 1'b0);
        push_fields(FUNC_MODE, 0, CMD_START, 3, 0, 12000, 500, 1'b0);
        push_fields(FUNC_SPARE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b1);
        wait_drained();

        apply_setting(1, 0, 4095, 64, 100, 9000, 5000);
        push_fields(FUNC_SCAN, 0, 0, 3, 0, 12000, 0, 1'b0);
        push_fields(FUNC_DUTY, 32767, 0, 3, 0, 12000, 0, 1'b0);
        push_fields(FUNC_DUTY, -32768, 0, 3, 0, 12000, 0, 1'b0);
        push_fields(FUNC_DUTY, 500, 0, 3, 0, 8999, 0, 1'b0);
        push_fields(FUNC_SCAN, 0, 0, 5, 5000, 9000, 0, 1'b0);
        push_fields(FUNC_MODE, 0, CMD_START, 0, 0, 0, 0, 1'b0);
        push_fields(FUNC_MODE, 0, 7, 0, 0, 0, 101, 1'b0);
        push_fields(FUNC_DUTY, 4095, 0, 0, 0, 65535, 0, 1'b0);
        push_fields(FUNC_DUTY, 4095, 0, 0, 0, 65535, 0, 1'b0);
        push_fields(FUNC_SCAN, 0, 0, 6, -5000, 9000, 99, 1'b0);
        push_fields(FUNC_MODE, 0, CMD_START, 0, 0, 0, 50, 1'b0);
        push_fields(FUNC_MODE, 0, CMD_CLEAR, 0, 0, 0, 0, 1'b0);
        push_fields(FUNC_SCAN, 0, 0, 0, 5001, 0, 65535, 1'b0);
        push_fields(FUNC_DUTY, 1000, 0, 0, 0, 65535, 0, 1'b0);
        push_fields(FUNC_SCAN, 0, 0, 7, -32768, 65535, 65535, 1'b0);
        push_fields(FUNC_SCAN, 0, 0, 1, 0, 65535, 65535, 1'b0);
        push_fields(FUNC_MODE, 0, CMD_CLEAR, 0, 0, 0, 0, 1'b0);
        push_fields(FUNC_MODE, 0, CMD_START, 0, 0, 0, 0, 1'b0);
        push_fields(FUNC_SCAN, 0, 0, 0, 0, 65535, 0, 1'b0);
        push_fields(FUNC_MODE, 0, CMD_STOP, 0, 0, 0, 65535, 1'b0);
        push_fields(FUNC_DUTY, 200, 0, 0, 0, 65535, 0, 1'b1);
        wait_drained();

        // inverted window, then zero slew step
        apply_setting(1, 3000, 1000, 4095, 100, 0, 5000);
        push_fields(FUNC_SCAN, 0, 0, 2, 0, 65535, 0, 1'b0);
        push_fields(FUNC_DUTY, 0, 0, 0, 0, 0, 0, 1'b0);
        push_fields(FUNC_DUTY, 2000, 0, 0, 0, 0, 0, 1'b0);
        push_fields(FUNC_DUTY, 4095, 0, 0, 0, 0, 0, 1'b0);
        wait_drained();
        apply_setting(1, 0, 4095, 0, 100, 0, 5000);
        push_fields(FUNC_DUTY, 4095, 0, 0, 0, 0, 0, 1'b0);
        wait_drained();

        for (p = 0; p < PHASES; p++) begin
            no_idle = (p % 4 == 1);
            case (p)
                0: apply_setting(1, 0, 4095, 64, 100, 9000, 5000);
                1: apply_setting(1, 0, 4095, 4095, 0, 0, 0);
                2: apply_setting(1, 4095, 4095, 1, 65535, 65535, 32767);
                3: apply_setting(1, 3000, 1000, 500, 2000, 12000, 8000);
                4: apply_setting(0, 100, 3000, 200, 500, 9000, 5000);
                5: apply_setting(1, 200, 3800, 0, 300, 10000, 3000);
                default: begin
                    apply_setting(($urandom_range(0, 9) != 0), $urandom_range(0, 1500),
                                  $urandom_range(2000, 4095), $urandom_range(1, 300),
                                  $urandom_range(0, 3000), $urandom_range(5000, 15000),
                                  $urandom_range(1000, 20000));
                end
            endcase
            repeat (PHASE_WORDS) push_word(rand_word());
            wait_drained();
        end
        no_idle = 1'b0;
        repeat (5) @(posedge i_clk);

        $display("Checked %0d result words under %0d register settings, %0d mismatches.",
                 results_checked, settings_applied, failures);
        $display("Run mode in %0d results, %0d trips to zero, %0d undervolt refusals.",
                 run_results, trip_results, uv_refusals);
        if (failures == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
